// ===== rtl/px2a_pkg.sv =====
// px2a_pkg: shared types, constants and the character ramp for the pixel to text block
// used by every module of pixel_stream_to_ascii_art; depends on nothing
package px2a_pkg;

  localparam int unsigned DIM_W    = 13;   // width of a frame or text dimension
  localparam int unsigned POS_W    = 12;   // width of a row or column position
  localparam int unsigned ACC_W    = 26;   // width of the sampling accumulators
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned LUMA_W   = 16;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned RAMP_LEN = 71;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS     = 4'd3;

  // register reset values
  localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 13'd480;
  localparam logic [DIM_W-1:0] RST_TEXT_COLUMNS  = 13'd80;
  localparam logic [DIM_W-1:0] RST_TEXT_ROWS     = 13'd40;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0a;
  localparam logic [IDX_W-1:0]  IDX_MAX      = 7'(RAMP_LEN - 1);

  // dark to light
  localparam logic [CHAR_W-1:0] RAMP_CHARS [RAMP_LEN] = '{
    7'h24, 7'h40, 7'h42, 7'h25, 7'h25, 7'h38, 7'h26, 7'h57, 7'h4d, 7'h23, 7'h2a,
    7'h6f, 7'h61, 7'h68, 7'h6b, 7'h62, 7'h64, 7'h70, 7'h71, 7'h77, 7'h6d,
    7'h5a, 7'h4f, 7'h30, 7'h51, 7'h4c, 7'h43, 7'h4a, 7'h55, 7'h59, 7'h58,
    7'h7a, 7'h63, 7'h76, 7'h75, 7'h6e, 7'h78, 7'h72, 7'h6a, 7'h66, 7'h74,
    7'h2f, 7'h5c, 7'h7c, 7'h28, 7'h29, 7'h31, 7'h7b, 7'h7d, 7'h5b, 7'h5d,
    7'h3f, 7'h2d, 7'h5f, 7'h2b, 7'h7e, 7'h3c, 7'h3e, 7'h69, 7'h21, 7'h6c,
    7'h49, 7'h3b, 7'h3a, 7'h2c, 7'h22, 7'h5e, 7'h60, 7'h27, 7'h2e, 7'h20
  };

  // effective frame and text dimensions
  typedef struct packed {
    logic [DIM_W-1:0] big_w;
    logic [DIM_W-1:0] big_h;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } dims_t;

  // what one accepted pixel produces
  typedef struct packed {
    logic char_en;
    logic nl_en;
  } emit_t;

  // results ready to be queued
  typedef struct packed {
    logic              char_en;
    logic              nl_en;
    logic [CHAR_W-1:0] code;
  } push_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } result_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = 13'd1;
    else if (v > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  function automatic dims_t make_dims(input logic [DIM_W-1:0] src_w,
                                      input logic [DIM_W-1:0] src_h,
                                      input logic [DIM_W-1:0] cols,
                                      input logic [DIM_W-1:0] rows);
    dims_t d;
    d.big_w = eff_dim(src_w);
    d.big_h = eff_dim(src_h);
    d.w     = (cols > d.big_w) ? d.big_w : cols;
    d.h     = (rows > d.big_h) ? d.big_h : rows;
    return d;
  endfunction

endpackage

// ===== rtl/px2a_cfg.sv =====
// px2a_cfg: configuration registers and their effective, clamped dimensions
// depends on px2a_pkg
module px2a_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [px2a_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [px2a_pkg::DIM_W-1:0]     wr_data,
  output logic                           restart,
  output px2a_pkg::dims_t                dims,
  output px2a_pkg::dims_t                dims_next
);

  logic [px2a_pkg::DIM_W-1:0] source_width, source_height, text_columns, text_rows;
  logic [px2a_pkg::DIM_W-1:0] source_width_next, source_height_next;
  logic [px2a_pkg::DIM_W-1:0] text_columns_next, text_rows_next;
  logic                       hit;

  always_comb begin
    source_width_next  = source_width;
    source_height_next = source_height;
    text_columns_next  = text_columns;
    text_rows_next     = text_rows;
    hit                = 1'b0;
    if (rst) begin
      source_width_next  = px2a_pkg::RST_SOURCE_WIDTH;
      source_height_next = px2a_pkg::RST_SOURCE_HEIGHT;
      text_columns_next  = px2a_pkg::RST_TEXT_COLUMNS;
      text_rows_next     = px2a_pkg::RST_TEXT_ROWS;
    end else if (wr_en) begin
      unique case (wr_index)
        px2a_pkg::REG_SOURCE_WIDTH: begin
          source_width_next = wr_data;
          hit = 1'b1;
        end
        px2a_pkg::REG_SOURCE_HEIGHT: begin
          source_height_next = wr_data;
          hit = 1'b1;
        end
        px2a_pkg::REG_TEXT_COLUMNS: begin
          text_columns_next = wr_data;
          hit = 1'b1;
        end
        px2a_pkg::REG_TEXT_ROWS: begin
          text_rows_next = wr_data;
          hit = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    source_width  <= source_width_next;
    source_height <= source_height_next;
    text_columns  <= text_columns_next;
    text_rows     <= text_rows_next;
  end

  assign restart   = hit;
  assign dims      = px2a_pkg::make_dims(source_width, source_height,
                                         text_columns, text_rows);
  assign dims_next = px2a_pkg::make_dims(source_width_next, source_height_next,
                                         text_columns_next, text_rows_next);

endmodule

// ===== rtl/px2a_sampler.sv =====
// px2a_sampler: raster position tracking and nearest-neighbour keep decisions
// depends on px2a_pkg
module px2a_sampler (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  px2a_pkg::dims_t   dims,
  input  px2a_pkg::dims_t   dims_next,
  input  logic              accept,
  output px2a_pkg::emit_t   emit
);

  localparam int unsigned DW = px2a_pkg::DIM_W;
  localparam int unsigned PW = px2a_pkg::POS_W;
  localparam int unsigned AW = px2a_pkg::ACC_W;

  logic [PW-1:0] column_position, column_position_next;
  logic [PW-1:0] row_position, row_position_next;
  logic [DW-1:0] columns_emitted, columns_emitted_next;
  logic [DW-1:0] rows_emitted, rows_emitted_next;
  logic [AW-1:0] column_target_acc, column_target_acc_next;
  logic [AW-1:0] column_bound_acc, column_bound_acc_next;
  logic [AW-1:0] row_target_acc, row_target_acc_next;
  logic [AW-1:0] row_bound_acc, row_bound_acc_next;
  logic          row_kept, row_kept_next;

  logic          rk, keep, col_end, row_end;
  logic [AW-1:0] step_big_w, step_big_h, step_w, step_h;

  assign step_big_w = AW'({dims.big_w, 1'b0});
  assign step_big_h = AW'({dims.big_h, 1'b0});
  assign step_w     = AW'({dims.w, 1'b0});
  assign step_h     = AW'({dims.h, 1'b0});

  always_comb begin
    rk = (column_position == '0)
         ? (rows_emitted < dims.h && row_target_acc < row_bound_acc)
         : row_kept;
    keep    = rk && columns_emitted < dims.w && column_target_acc < column_bound_acc;
    col_end = ({1'b0, column_position} + DW'(1)) >= dims.big_w;
    row_end = ({1'b0, row_position} + DW'(1)) >= dims.big_h;

    column_position_next   = column_position + PW'(1);
    columns_emitted_next   = columns_emitted + DW'(keep);
    column_target_acc_next = keep ? column_target_acc + step_big_w : column_target_acc;
    column_bound_acc_next  = column_bound_acc + step_w;
    row_position_next      = row_position;
    rows_emitted_next      = rows_emitted;
    row_target_acc_next    = row_target_acc;
    row_bound_acc_next     = row_bound_acc;
    row_kept_next          = rk;

    if (col_end) begin
      rows_emitted_next      = rows_emitted + DW'(rk);
      row_target_acc_next    = rk ? row_target_acc + step_big_h : row_target_acc;
      row_bound_acc_next     = row_bound_acc + step_h;
      column_position_next   = '0;
      columns_emitted_next   = '0;
      column_target_acc_next = AW'(dims.w);
      column_bound_acc_next  = step_w;
      if (row_end) begin
        row_position_next   = '0;
        rows_emitted_next   = '0;
        row_target_acc_next = AW'(dims.h);
        row_bound_acc_next  = step_h;
        row_kept_next       = 1'b0;
      end else begin
        row_position_next = row_position + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_position   <= '0;
      row_position      <= '0;
      columns_emitted   <= '0;
      rows_emitted      <= '0;
      column_target_acc <= AW'(dims_next.w);
      column_bound_acc  <= AW'({dims_next.w, 1'b0});
      row_target_acc    <= AW'(dims_next.h);
      row_bound_acc     <= AW'({dims_next.h, 1'b0});
      row_kept          <= 1'b0;
    end else if (accept) begin
      column_position   <= column_position_next;
      row_position      <= row_position_next;
      columns_emitted   <= columns_emitted_next;
      rows_emitted      <= rows_emitted_next;
      column_target_acc <= column_target_acc_next;
      column_bound_acc  <= column_bound_acc_next;
      row_target_acc    <= row_target_acc_next;
      row_bound_acc     <= row_bound_acc_next;
      row_kept          <= row_kept_next;
    end
  end

  assign emit.char_en = keep;
  assign emit.nl_en   = col_end && rk;

endmodule

// ===== rtl/px2a_glyph.sv =====
// px2a_glyph: two-stage luma and ramp character pipeline
// depends on px2a_pkg
module px2a_glyph (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  px2a_pkg::emit_t emit,
  input  logic [7:0]      red_level,
  input  logic [7:0]      green_level,
  input  logic [7:0]      blue_level,
  output px2a_pkg::push_t push,
  output logic [2:0]      pending
);

  localparam int unsigned LW = px2a_pkg::LUMA_W;

  px2a_pkg::emit_t        a_emit, b_emit;
  logic [7:0]             a_red, a_green, a_blue;
  logic [LW-1:0]          a_luma, b_luma;
  logic [22:0]            scaled;
  logic [15:0]            coarse, inc, quot;
  logic [px2a_pkg::IDX_W-1:0] idx;

  // luma in Q8: 54r + 184g + 18b, at most 65280
  assign a_luma = LW'(16'(a_red) * 16'd54 + 16'(a_green) * 16'd184
                      + 16'(a_blue) * 16'd18);

  // index = floor((71 L + 32640) / 65280); 65280 = 256 * 255, so shift then divide by 255
  always_comb begin
    scaled = 23'(b_luma) * 23'(px2a_pkg::RAMP_LEN) + 23'd32640;
    coarse = 16'(scaled[22:8]);
    inc    = coarse + 16'd1;
    quot   = (inc + (inc >> 8)) >> 8;
    idx    = (quot > 16'(px2a_pkg::IDX_MAX)) ? px2a_pkg::IDX_MAX
                                             : px2a_pkg::IDX_W'(quot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_emit <= '0;
      b_emit <= '0;
    end else begin
      a_emit <= accept ? emit : '0;
      b_emit <= a_emit;
    end
    a_red   <= red_level;
    a_green <= green_level;
    a_blue  <= blue_level;
    b_luma  <= a_luma;
  end

  assign push.char_en = b_emit.char_en;
  assign push.nl_en   = b_emit.nl_en;
  assign push.code    = px2a_pkg::RAMP_CHARS[idx];

  assign pending = 3'(a_emit.char_en) + 3'(a_emit.nl_en)
                 + 3'(b_emit.char_en) + 3'(b_emit.nl_en);

endmodule

// ===== rtl/px2a_fifo.sv =====
// px2a_fifo: eight-entry result queue taking up to two results per cycle
// depends on px2a_pkg
module px2a_fifo (
  input  logic              clk,
  input  logic              rst,
  input  px2a_pkg::push_t   push,
  input  logic              pop,
  output logic              not_empty,
  output px2a_pkg::result_t head,
  output logic [3:0]        count
);

  px2a_pkg::result_t mem [8];
  logic [2:0]        wp, rp;
  logic [1:0]        n_push;
  logic              do_pop;

  assign n_push    = 2'(push.char_en) + 2'(push.nl_en);
  assign do_pop    = pop && (count != '0);
  assign not_empty = (count != '0);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + 3'(n_push);
      rp    <= rp + 3'(do_pop);
      count <= count + 4'(n_push) - 4'(do_pop);
    end
    // character first, newline after it; last marks the final result of the pixel
    if (push.char_en) begin
      mem[wp] <= '{code: push.code, last: !push.nl_en};
      if (push.nl_en) mem[wp + 3'd1] <= '{code: px2a_pkg::CHAR_NEWLINE, last: 1'b1};
    end else if (push.nl_en) begin
      mem[wp] <= '{code: px2a_pkg::CHAR_NEWLINE, last: 1'b1};
    end
  end

endmodule

// ===== rtl/pixel_stream_to_ascii_art.sv =====
// pixel_stream_to_ascii_art: top level of the pixel to text converter
// depends on px2a_pkg, px2a_cfg, px2a_sampler, px2a_glyph, px2a_fifo
//
// usage
//   s_* : rgb pixels of a frame in raster order, one per transaction
//         (s_tdata: red_level [7:0], green_level [15:8], blue_level [23:16])
//   m_* : text characters, one per transaction; m_tdata[6:0] is the ascii code,
//         a ramp character for each kept pixel or a newline at the end of a kept
//         row; m_tlast marks the final character caused by one pixel
//   cfg_* : register writes (0 source width, 1 source height, 2 text columns,
//         3 text rows); any write to a listed register restarts the frame, other
//         indexes are ignored; cfg_ready is always high
// throughput: one pixel per cycle while the result queue has room; a pixel
//   causing two characters (last kept column of a kept row) needs two output
//   transactions, so the output port sets the sustained rate for such rows
// output path: a pixel's first character passes the two pipeline registers,
//   then the result queue, before it is offered
// reset: registers return to 640x480 into 80x40, positions go to frame start,
//   the queue empties
// stall: when m_tready is low the queue fills and s_tready drops once fewer
//   than two free slots remain beyond the results still in the pipeline
module pixel_stream_to_ascii_art (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_level [7:0], green_level [15:8], blue_level [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // text_char [6:0], zero [7]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic              restart, accept, fifo_not_empty;
  px2a_pkg::dims_t   dims, dims_next;
  px2a_pkg::emit_t   emit;
  px2a_pkg::push_t   push;
  px2a_pkg::result_t head;
  logic [2:0]        pending;
  logic [3:0]        fifo_count;
  logic [4:0]        reserved;

  assign cfg_ready = 1'b1;

  px2a_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .restart   (restart),
    .dims      (dims),
    .dims_next (dims_next)
  );

  // room for the queue contents, results in flight and two more
  assign reserved = 5'(fifo_count) + 5'(pending) + 5'd2;
  assign s_tready = (reserved <= 5'd8);
  assign accept   = s_tvalid && s_tready;

  px2a_sampler u_sampler (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .dims      (dims),
    .dims_next (dims_next),
    .accept    (accept),
    .emit      (emit)
  );

  px2a_glyph u_glyph (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .emit        (emit),
    .red_level   (s_tdata[7:0]),
    .green_level (s_tdata[15:8]),
    .blue_level  (s_tdata[23:16]),
    .push        (push),
    .pending     (pending)
  );

  px2a_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tready),
    .not_empty (fifo_not_empty),
    .head      (head),
    .count     (fifo_count)
  );

  assign m_tvalid = fifo_not_empty;
  assign m_tdata  = {1'b0, head.code};
  assign m_tlast  = head.last;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for pixel_stream_to_ascii_art, pixels in, text characters out
// keeps its own sampling and luma ramp predictor and compares every character in order
// depends on px2a_pkg and pixel_stream_to_ascii_art
module tb_top;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  // first character passes two pipeline registers and the queue; this covers pixels with no output
  localparam int SETTLE_CYCLES = 8;
  // idle cycles allowed with no transaction on any channel; random stalls stay far below
  localparam int STALL_LIMIT   = 4000;
  localparam int PIXEL_TARGET  = 1250;
  localparam int IDX_TOP       = (1 << px2a_pkg::CFG_IDX_W) - 1;

  // luma ramp, dark to light, first glyph in the top byte
  localparam logic [8*71-1:0] GLYPH_RAMP = {
    8'h24, 8'h40, 8'h42, 8'h25, 8'h25, 8'h38, 8'h26, 8'h57, 8'h4d, 8'h23, 8'h2a,
    8'h6f, 8'h61, 8'h68, 8'h6b, 8'h62, 8'h64, 8'h70, 8'h71, 8'h77, 8'h6d,
    8'h5a, 8'h4f, 8'h30, 8'h51, 8'h4c, 8'h43, 8'h4a, 8'h55, 8'h59, 8'h58,
    8'h7a, 8'h63, 8'h76, 8'h75, 8'h6e, 8'h78, 8'h72, 8'h6a, 8'h66, 8'h74,
    8'h2f, 8'h5c, 8'h7c, 8'h28, 8'h29, 8'h31, 8'h7b, 8'h7d, 8'h5b, 8'h5d,
    8'h3f, 8'h2d, 8'h5f, 8'h2b, 8'h7e, 8'h3c, 8'h3e, 8'h69, 8'h21, 8'h6c,
    8'h49, 8'h3b, 8'h3a, 8'h2c, 8'h22, 8'h5e, 8'h60, 8'h27, 8'h2e, 8'h20
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    logic [px2a_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_item_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;   // red_level [7:0], green_level [15:8], blue_level [23:16]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;          // text_char [6:0], zero [7]
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [12:0] cfg_data  = '0;

  pixel_t     pixel_queue [$];     // pixels waiting to be offered
  text_item_t text_expected [$];   // characters the block still owes

  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  int   pixels_queued = 0;
  int   error_count   = 0;
  int   stall_cycles  = 0;
  logic pixel_taken   = 1'b0;      // pixel transaction at the last rising edge

  // predictor copy of the registers and the sampling state
  logic [px2a_pkg::DIM_W-1:0] reg_src_w, reg_src_h, reg_cols, reg_rows;
  int unsigned col_pos, row_pos, cols_done, rows_done;
  int unsigned col_tgt, col_bnd, row_tgt, row_bnd;
  bit          row_on;

  pixel_stream_to_ascii_art dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // frame size as the block uses it: zero reads as one, oversize as the bound
  function automatic int unsigned frame_dim(logic [px2a_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > px2a_pkg::MAX_DIM) return px2a_pkg::MAX_DIM;
    return v;
  endfunction

  // text size never exceeds the frame size
  function automatic int unsigned text_dim(logic [px2a_pkg::DIM_W-1:0] v, int unsigned big);
    return (v > big) ? big : v;
  endfunction

  function automatic void start_text_row();
    col_pos   = 0;
    cols_done = 0;
    col_tgt   = text_dim(reg_cols, frame_dim(reg_src_w));
    col_bnd   = 2 * col_tgt;
  endfunction

  function automatic void start_text_frame();
    start_text_row();
    row_pos   = 0;
    rows_done = 0;
    row_tgt   = text_dim(reg_rows, frame_dim(reg_src_h));
    row_bnd   = 2 * row_tgt;
    row_on    = 1'b0;
  endfunction

  // q8 luma, then half-up rounding onto the ramp, clamped to its last glyph
  function automatic logic [px2a_pkg::CHAR_W-1:0] glyph_for(logic [7:0] r, logic [7:0] g,
                                                            logic [7:0] b);
    int unsigned luma, idx;
    luma = 54 * r + 184 * g + 18 * b;
    idx  = (2 * luma * px2a_pkg::RAMP_LEN + 65280) / 130560;
    if (idx > px2a_pkg::RAMP_LEN - 1) idx = px2a_pkg::RAMP_LEN - 1;
    return GLYPH_RAMP[8 * (px2a_pkg::RAMP_LEN - 1 - idx) +: px2a_pkg::CHAR_W];
  endfunction

  // advance the sampler by one pixel and queue the characters it causes
  function automatic void predict_pixel(logic [23:0] data);
    logic [px2a_pkg::CHAR_W-1:0] codes [2];
    text_item_t                  item;
    int                          n;
    int unsigned                 big_w, big_h, w, h;
    big_w = frame_dim(reg_src_w);
    big_h = frame_dim(reg_src_h);
    w     = text_dim(reg_cols, big_w);
    h     = text_dim(reg_rows, big_h);
    n     = 0;

    // row decision is taken on the first pixel of each source row
    if (col_pos == 0) row_on = (rows_done < h) && (row_tgt < row_bnd);

    if (row_on && cols_done < w && col_tgt < col_bnd) begin
      codes[n] = glyph_for(data[7:0], data[15:8], data[23:16]);
      n++;
      cols_done++;
      col_tgt += 2 * big_w;
    end
    col_bnd += 2 * w;

    if (col_pos + 1 >= big_w) begin
      // end of source row: newline if the row was kept
      if (row_on) begin
        codes[n] = px2a_pkg::CHAR_NEWLINE;
        n++;
        rows_done++;
        row_tgt += 2 * big_h;
      end
      row_bnd += 2 * h;
      if (row_pos + 1 >= big_h) begin
        start_text_frame();   // frame wraps
      end else begin
        row_pos++;
        start_text_row();
      end
    end else begin
      col_pos++;
    end

    for (int i = 0; i < n; i++) begin
      item.code = codes[i];
      item.last = (i == n - 1);
      text_expected.push_back(item);
    end
  endfunction

  // a write to a listed register restarts the frame, other indexes change nothing
  function automatic void write_predicted_register(logic [3:0] idx, logic [12:0] v);
    case (idx)
      px2a_pkg::REG_SOURCE_WIDTH:  reg_src_w = v;
      px2a_pkg::REG_SOURCE_HEIGHT: reg_src_h = v;
      px2a_pkg::REG_TEXT_COLUMNS:  reg_cols  = v;
      px2a_pkg::REG_TEXT_ROWS:     reg_rows  = v;
      default:                     return;
    endcase
    start_text_frame();
  endfunction

  // ---------------------------------------------------------------- drivers

  // pixel source: holds a pixel until its transaction, may idle between pixels
  always @(negedge clk) begin : pixel_driver
    pixel_t px;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || pixel_taken) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        px = pixel_queue.pop_front();
        s_tdata  <= {px.blue, px.green, px.red};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // text sink: back-pressure at random
  always @(negedge clk) begin : text_sink
    m_tready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  // ---------------------------------------------------------------- monitor

  // predicts on accepted pixels and register writes, checks every character in order
  always @(posedge clk) begin : monitor
    text_item_t want;
    if (rst) begin
      reg_src_w    = px2a_pkg::RST_SOURCE_WIDTH;
      reg_src_h    = px2a_pkg::RST_SOURCE_HEIGHT;
      reg_cols     = px2a_pkg::RST_TEXT_COLUMNS;
      reg_rows     = px2a_pkg::RST_TEXT_ROWS;
      start_text_frame();
      pixel_taken  = 1'b0;
      stall_cycles = 0;
    end else begin
      pixel_taken = s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) write_predicted_register(cfg_index, cfg_data);
      if (pixel_taken) predict_pixel(s_tdata);

      if (m_tvalid && m_tready) begin
        if (text_expected.size() == 0) begin
          $error("text_char: expected nothing, got %h", m_tdata[6:0]);
          error_count++;
        end else begin
          want = text_expected.pop_front();
          if (m_tdata[6:0] !== want.code) begin
            $error("text_char: expected %h, got %h", want.code, m_tdata[6:0]);
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, m_tlast);
            error_count++;
          end
          if (m_tdata[7] !== 1'b0) begin
            $error("m_tdata pad: expected 0, got %b", m_tdata[7]);
            error_count++;
          end
        end
      end

      // watchdog on cycles with no transaction anywhere
      if (pixel_taken || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("pixel_stream_to_ascii_art: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one register write, valid dropped again on the following falling edge
  task automatic write_register(input logic [3:0] idx, input logic [12:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [12:0] sw, input logic [12:0] sh,
                           input logic [12:0] tc, input logic [12:0] tr);
    write_register(px2a_pkg::REG_SOURCE_WIDTH, sw);
    write_register(px2a_pkg::REG_SOURCE_HEIGHT, sh);
    write_register(px2a_pkg::REG_TEXT_COLUMNS, tc);
    write_register(px2a_pkg::REG_TEXT_ROWS, tr);
  endtask

  // extremes come up often so every ramp end is exercised
  function automatic logic [7:0] random_level();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // queue n random pixels, then wait until every character is back and the pipe is empty
  task automatic run_pixels(input int n);
    pixel_t px;
    // idling pattern moves through three stages over the run
    if (pixels_queued < PIXEL_TARGET / 3) begin
      src_idle_pct  = 16;
      sink_idle_pct = 62;
    end else if (pixels_queued < 2 * PIXEL_TARGET / 3) begin
      src_idle_pct  = 62;
      sink_idle_pct = 16;
    end else begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end
    for (int i = 0; i < n; i++) begin
      px.red   = random_level();
      px.green = random_level();
      px.blue  = random_level();
      pixel_queue.push_back(px);
    end
    pixels_queued += n;
    while (pixel_queue.size() != 0 || s_tvalid || text_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [12:0] sw, sh;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register reset values, part of the first row of a 640x480 frame
    run_pixels(150);

    // small frame, every pixel kept; channel extremes then enough to wrap the frame
    configure(13'd4, 13'd3, 13'd4, 13'd3);
    pixel_queue.push_back('{8'h00, 8'h00, 8'h00});
    pixel_queue.push_back('{8'hff, 8'hff, 8'hff});   // ramp index clamps here
    pixel_queue.push_back('{8'hff, 8'h00, 8'h00});
    pixel_queue.push_back('{8'h00, 8'hff, 8'h00});
    pixel_queue.push_back('{8'h00, 8'h00, 8'hff});
    pixel_queue.push_back('{8'h80, 8'h80, 8'h80});
    pixel_queue.push_back('{8'h01, 8'h01, 8'h01});
    pixel_queue.push_back('{8'hfe, 8'hfe, 8'hfe});
    run_pixels(12);

    // zero frame size reads as 1x1, text size clamped: a glyph and a newline per pixel
    configure(13'd0, 13'd0, 13'd5, 13'h1fff);
    run_pixels(40);

    // frame size at and above the bound, text size above and at the frame size
    configure(13'd4096, 13'h1fff, 13'h1fff, 13'd4096);
    run_pixels(30);

    // no text columns: kept rows give only newlines
    configure(13'd7, 13'd5, 13'd0, 13'd5);
    run_pixels(60);

    // no text rows: no output at all
    configure(13'd9, 13'd6, 13'd3, 13'd0);
    run_pixels(40);

    // random settings, some writes left out, unlisted indexes now and then
    while (pixels_queued < PIXEL_TARGET) begin
      case ($urandom_range(9))
        0:       sw = 13'd0;
        1:       sw = 13'($urandom_range(4097, 8191));
        default: sw = 13'($urandom_range(1, 12));
      endcase
      case ($urandom_range(9))
        0:       sh = 13'd0;
        1:       sh = 13'($urandom_range(4097, 8191));
        default: sh = 13'($urandom_range(1, 8));
      endcase
      if ($urandom_range(3) == 0)
        write_register(4'($urandom_range(px2a_pkg::REG_TEXT_ROWS + 1, IDX_TOP)),
                       13'($urandom_range(8191)));
      if ($urandom_range(4) != 0) write_register(px2a_pkg::REG_SOURCE_WIDTH, sw);
      if ($urandom_range(4) != 0) write_register(px2a_pkg::REG_SOURCE_HEIGHT, sh);
      if ($urandom_range(4) != 0)
        write_register(px2a_pkg::REG_TEXT_COLUMNS, 13'($urandom_range(14)));
      if ($urandom_range(4) != 0)
        write_register(px2a_pkg::REG_TEXT_ROWS, 13'($urandom_range(10)));
      run_pixels($urandom_range(20, 120));
    end

    if (error_count == 0) begin
      $display("pixel_stream_to_ascii_art: match");
    end else begin
      $display("pixel_stream_to_ascii_art: mismatch");
    end
    $finish;
  end

endmodule
